[src/assert_macros.svh]
// assertion macros shared by the rtl files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked check on clk, off while rst_n is low
`define ASSERT_CLKD(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// same-cycle implication
`define ASSERT_IMPLY(lbl, ante, cons, msg) \
    `ASSERT_CLKD(lbl, (ante) |-> (cons), msg)

// next-cycle implication
`define ASSERT_NEXT(lbl, ante, cons, msg) \
    `ASSERT_CLKD(lbl, (ante) |=> (cons), msg)

`endif

[src/nst_pkg.sv]
// shared types and constants of the named semaphore table
package nst_pkg;

    localparam int NUM_SEMS_DEF    = 16;
    localparam int QUEUE_DEPTH_DEF = 16;
    localparam int NAME_BYTES_DEF  = 8;

    localparam int KEY_W    = 64;
    localparam int INIT_W   = 16;
    localparam int PID_W    = 8;
    localparam int STATUS_W = 3;
    localparam int CNT_W    = 17;
    localparam int OPENS_W  = 8;

    typedef enum logic [1:0] {
        CMD_OPEN  = 2'd0,
        CMD_WAIT  = 2'd1,
        CMD_POST  = 2'd2,
        CMD_CLOSE = 2'd3
    } cmd_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK       = 3'd0,
        ST_EXISTS   = 3'd1,
        ST_NOSLOT   = 3'd2,
        ST_NOTFOUND = 3'd3,
        ST_QFULL    = 3'd4
    } status_t;

    localparam logic signed [CNT_W-1:0] CNT_MAX  = 17'sd65535;
    localparam logic signed [CNT_W-1:0] CNT_ZERO = 17'sd0;
    localparam logic signed [CNT_W-1:0] CNT_ONE  = 17'sd1;
    localparam logic [OPENS_W-1:0]      OPENS_MAX = 8'd255;

endpackage

[src/nst_ifs.sv]
// request and response channel interfaces
interface nst_req_if import nst_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [1:0]          cmd;
    logic [KEY_W-1:0]    name_key;
    logic [INIT_W-1:0]   init_value;
    logic [PID_W-1:0]    caller_pid;

    modport source (output valid, output cmd, output name_key, output init_value,
                    output caller_pid, input ready);
    modport sink (input valid, input cmd, input name_key, input init_value,
                  input caller_pid, output ready);
endinterface

interface nst_rsp_if import nst_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic                must_block;
    logic                wake_valid;
    logic [PID_W-1:0]    wake_pid;

    modport source (output valid, output status, output must_block, output wake_valid,
                    output wake_pid, input ready);
    modport sink (input valid, input status, input must_block, input wake_valid,
                  input wake_pid, output ready);
endinterface

[src/nst_pid_ram.sv]
// wait queue storage: one pid ring per slot, one write and one read port
module nst_pid_ram import nst_pkg::*; #(
    parameter int DEPTH = NUM_SEMS_DEF * QUEUE_DEPTH_DEF,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [PID_W-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [PID_W-1:0] rdata
);

    logic [PID_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

[src/named_semaphore_table.sv]
// named semaphore table top level: slot search, read-modify-write, response register
//
//  channel | dir | words
//  --------+-----+---------------------------------------------------
//  req     | in  | cmd, name_key, init_value, caller_pid
//  rsp     | out | status, must_block, wake_valid, wake_pid
//
// one request at a time; a request is taken in S_IDLE, then S_SCAN reads the slot memory
// at one slot per cycle (stops at the matching slot), S_EXEC does the read-modify-write
// of the slot and S_OUT loads the response register.
// used bits are flops cleared by reset; the slot and pid memories need no clearing.
// a stalled rsp holds its word; a new request is taken while a response waits.
`include "assert_macros.svh"

module named_semaphore_table import nst_pkg::*; #(
    parameter int NUM_SEMS    = NUM_SEMS_DEF,
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
    parameter int NAME_BYTES  = NAME_BYTES_DEF
) (
    input  logic   clk,
    input  logic   rst_n,
    nst_req_if.sink   req,
    nst_rsp_if.source rsp
);

    localparam int SW = (NUM_SEMS > 1) ? $clog2(NUM_SEMS) : 1;
    localparam int CW = $clog2(NUM_SEMS + 1);
    localparam int QW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int LW = $clog2(QUEUE_DEPTH + 1);
    localparam int PW = LW + 1;
    localparam int KW = 8 * NAME_BYTES;
    localparam int PD = NUM_SEMS * QUEUE_DEPTH;
    localparam int AW = (PD > 1) ? $clog2(PD) : 1;

    typedef struct packed {
        logic [KW-1:0]             key;
        logic signed [CNT_W-1:0]   cnt;
        logic [OPENS_W-1:0]        opens;
        logic [QW-1:0]             head;
        logic [LW-1:0]             len;
    } ent_t;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_SCAN = 4'b0010,
        S_EXEC = 4'b0100,
        S_OUT  = 4'b1000
    } state_t;

    state_t state_reg, state_next;

    // request capture
    cmd_t              cmd_reg;
    logic [KW-1:0]     key_reg;
    logic [INIT_W-1:0] init_reg;
    logic [PID_W-1:0]  pid_reg;

    // scan
    logic [CW-1:0]       iss_reg;
    logic                cmp_vld_reg;
    logic [SW-1:0]       cmp_idx_reg;
    logic                free_vld_reg;
    logic [SW-1:0]       free_idx_reg;
    logic                hit_reg;
    logic [SW-1:0]       slot_reg;
    ent_t                ent_reg;
    logic [NUM_SEMS-1:0] used_reg;
    logic                issuing;
    logic                match;
    logic [SW-1:0]       iss_idx;

    // slot memory
    ent_t          slot_mem [NUM_SEMS];
    ent_t          slot_rd;
    logic          ent_we;
    logic [SW-1:0] ent_waddr;
    ent_t          ent_wdata;
    logic          set_used;
    logic          clr_used;

    // pid memory
    logic             pid_we;
    logic             pid_re;
    logic [AW-1:0]    pid_waddr;
    logic [AW-1:0]    pid_raddr;
    logic [PID_W-1:0] pid_rdata;

    // result and response
    status_t          res_status;
    logic             res_blk;
    logic             res_wake;
    status_t          res_status_reg;
    logic             res_blk_reg;
    logic             res_wake_reg;
    logic             rsp_vld_reg, rsp_vld_next;
    logic [STATUS_W-1:0] rsp_status_reg;
    logic             rsp_blk_reg;
    logic             rsp_wv_reg;
    logic [PID_W-1:0] rsp_pid_reg;
    logic             out_load;
    logic signed [CNT_W-1:0] wr_neg_cnt;

    assign req.ready = (state_reg == S_IDLE);
    assign rsp.valid      = rsp_vld_reg;
    assign rsp.status     = rsp_status_reg;
    assign rsp.must_block = rsp_blk_reg;
    assign rsp.wake_valid = rsp_wv_reg;
    assign rsp.wake_pid   = rsp_pid_reg;

    assign iss_idx = iss_reg[SW-1:0];
    assign issuing = (state_reg == S_SCAN) && (iss_reg < CW'(NUM_SEMS));
    assign match   = (state_reg == S_SCAN) && cmp_vld_reg && used_reg[cmp_idx_reg]
                     && (slot_rd.key == key_reg);
    assign out_load = (state_reg == S_OUT) && (!rsp_vld_reg || rsp.ready);
    assign wr_neg_cnt = -ent_wdata.cnt;

    always_ff @(posedge clk)
    begin
        if (ent_we)
        begin
            slot_mem[ent_waddr] <= ent_wdata;
        end
        if (issuing)
        begin
            slot_rd <= slot_mem[iss_idx];
        end
    end

    nst_pid_ram #(
        .DEPTH (PD),
        .AW    (AW)
    ) u_pid_ram (
        .clk   (clk),
        .we    (pid_we),
        .waddr (pid_waddr),
        .wdata (pid_reg),
        .re    (pid_re),
        .raddr (pid_raddr),
        .rdata (pid_rdata)
    );

    // read-modify-write of the selected slot
    always_comb
    begin
        logic [PW-1:0]           push_sum;
        logic [QW-1:0]           push_pos;
        logic [QW-1:0]           head_nx;
        logic signed [CNT_W-1:0] cnt_inc;
        logic [OPENS_W-1:0]      opens_dec;
        logic [AW-1:0]           slot_base;

        push_sum  = PW'(ent_reg.head) + PW'(ent_reg.len);
        push_pos  = (push_sum >= PW'(QUEUE_DEPTH)) ? QW'(push_sum - PW'(QUEUE_DEPTH))
                                                   : QW'(push_sum);
        head_nx   = (ent_reg.head == QW'(QUEUE_DEPTH - 1)) ? '0 : QW'(ent_reg.head + 1'b1);
        cnt_inc   = (ent_reg.cnt < CNT_MAX) ? ent_reg.cnt + CNT_ONE : ent_reg.cnt;
        opens_dec = (ent_reg.opens != '0) ? ent_reg.opens - 1'b1 : ent_reg.opens;
        slot_base = AW'(AW'(slot_reg) * AW'(QUEUE_DEPTH));

        ent_we     = 1'b0;
        ent_waddr  = slot_reg;
        ent_wdata  = ent_reg;
        set_used   = 1'b0;
        clr_used   = 1'b0;
        pid_we     = 1'b0;
        pid_re     = 1'b0;
        pid_waddr  = AW'(slot_base + AW'(push_pos));
        pid_raddr  = AW'(slot_base + AW'(ent_reg.head));
        res_status = ST_OK;
        res_blk    = 1'b0;
        res_wake   = 1'b0;

        if (state_reg == S_EXEC)
        begin
            if (cmd_reg == CMD_OPEN)
            begin
                if (hit_reg)
                begin
                    ent_we = 1'b1;
                    ent_wdata.opens = (ent_reg.opens < OPENS_MAX) ? ent_reg.opens + 1'b1
                                                                  : ent_reg.opens;
                    res_status = ST_EXISTS;
                end
                else if (free_vld_reg)
                begin
                    ent_we          = 1'b1;
                    set_used        = 1'b1;
                    ent_waddr       = free_idx_reg;
                    ent_wdata.key   = key_reg;
                    ent_wdata.cnt   = $signed(CNT_W'(init_reg));
                    ent_wdata.opens = OPENS_W'(1);
                    ent_wdata.head  = '0;
                    ent_wdata.len   = '0;
                end
                else
                begin
                    res_status = ST_NOSLOT;
                end
            end
            else if (!hit_reg)
            begin
                res_status = ST_NOTFOUND;
            end
            else
            begin
                case (cmd_reg)
                    CMD_WAIT:
                    begin
                        if (ent_reg.cnt <= CNT_ZERO)
                        begin
                            if (ent_reg.len >= LW'(QUEUE_DEPTH))
                            begin
                                res_status = ST_QFULL;
                            end
                            else
                            begin
                                ent_we        = 1'b1;
                                pid_we        = 1'b1;
                                ent_wdata.len = LW'(ent_reg.len + 1'b1);
                                ent_wdata.cnt = ent_reg.cnt - CNT_ONE;
                                res_blk       = 1'b1;
                            end
                        end
                        else
                        begin
                            ent_we        = 1'b1;
                            ent_wdata.cnt = ent_reg.cnt - CNT_ONE;
                        end
                    end
                    CMD_POST:
                    begin
                        ent_we        = 1'b1;
                        ent_wdata.cnt = cnt_inc;
                        if ((cnt_inc <= CNT_ZERO) && (ent_reg.len != '0))
                        begin
                            pid_re         = 1'b1;
                            res_wake       = 1'b1;
                            ent_wdata.head = head_nx;
                            ent_wdata.len  = LW'(ent_reg.len - 1'b1);
                        end
                    end
                    CMD_CLOSE:
                    begin
                        if (opens_dec == '0)
                        begin
                            clr_used = 1'b1;
                        end
                        else
                        begin
                            ent_we          = 1'b1;
                            ent_wdata.opens = opens_dec;
                        end
                    end
                    default:
                    begin
                        res_status = ST_OK;
                    end
                endcase
            end
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (match || !issuing)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (out_load)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        rsp_vld_next = rsp_vld_reg;
        if (out_load)
        begin
            rsp_vld_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            rsp_vld_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            iss_reg      <= '0;
            cmp_vld_reg  <= 1'b0;
            free_vld_reg <= 1'b0;
            hit_reg      <= 1'b0;
            used_reg     <= '0;
            rsp_vld_reg  <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            rsp_vld_reg <= rsp_vld_next;
            if ((state_reg == S_IDLE) && req.valid)
            begin
                iss_reg      <= '0;
                cmp_vld_reg  <= 1'b0;
                free_vld_reg <= 1'b0;
                hit_reg      <= 1'b0;
            end
            if (state_reg == S_SCAN)
            begin
                cmp_vld_reg <= issuing;
                if (issuing)
                begin
                    iss_reg <= CW'(iss_reg + 1'b1);
                    if (!used_reg[iss_idx] && !free_vld_reg)
                    begin
                        free_vld_reg <= 1'b1;
                    end
                end
                if (match)
                begin
                    hit_reg <= 1'b1;
                end
            end
            if (set_used)
            begin
                used_reg[free_idx_reg] <= 1'b1;
            end
            if (clr_used)
            begin
                used_reg[slot_reg] <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if ((state_reg == S_IDLE) && req.valid)
        begin
            cmd_reg  <= cmd_t'(req.cmd);
            key_reg  <= req.name_key[KW-1:0];
            init_reg <= req.init_value;
            pid_reg  <= req.caller_pid;
        end
        if (state_reg == S_SCAN)
        begin
            cmp_idx_reg <= iss_idx;
            if (issuing && !used_reg[iss_idx] && !free_vld_reg)
            begin
                free_idx_reg <= iss_idx;
            end
            if (match)
            begin
                slot_reg <= cmp_idx_reg;
                ent_reg  <= slot_rd;
            end
        end
        if (state_reg == S_EXEC)
        begin
            res_status_reg <= res_status;
            res_blk_reg    <= res_blk;
            res_wake_reg   <= res_wake;
        end
        if (out_load)
        begin
            rsp_status_reg <= res_status_reg;
            rsp_blk_reg    <= res_blk_reg;
            rsp_wv_reg     <= res_wake_reg;
            rsp_pid_reg    <= res_wake_reg ? pid_rdata : '0;
        end
    end

    `ASSERT_IMPLY(a_wake_ok, rsp.valid && rsp.wake_valid, rsp.status == ST_OK && !rsp.must_block, "wake word with bad status")
    `ASSERT_IMPLY(a_queue_len, ent_we && (ent_wdata.cnt < CNT_ZERO), wr_neg_cnt == $signed(CNT_W'(ent_wdata.len)), "queue length out of step with count")
    `ASSERT_IMPLY(a_hit_used, (state_reg == S_EXEC) && hit_reg, used_reg[slot_reg], "hit on a free slot")
    `ASSERT_NEXT(a_exec_out, state_reg == S_EXEC, state_reg == S_OUT && !hit_reg == !$past(hit_reg), "exec not followed by response load")

endmodule

[tb/tb.sv]
// testbench for the named semaphore table: directed table plus random traffic, predictor check
module tb import nst_pkg::*; ();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int NSEM        = NUM_SEMS_DEF;
    localparam int QDEPTH      = QUEUE_DEPTH_DEF;
    localparam int HEAD_W      = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int LEN_W       = $clog2(QDEPTH + 1);
    localparam int LATENCY     = NSEM + 4;
    localparam int POOL_SIZE   = 22;
    localparam int ITEM_TARGET = 1750;
    localparam logic [KEY_W-1:0] KEY_MASK =
        (NAME_BYTES_DEF >= 8) ? {KEY_W{1'b1}} : ((64'd1 << (8 * NAME_BYTES_DEF)) - 64'd1);
    localparam logic [KEY_W-1:0] KEY_ZERO = 64'h0;
    localparam logic [KEY_W-1:0] KEY_ONES = 64'hffff_ffff_ffff_ffff;
    localparam logic [KEY_W-1:0] KEY_ODD  = 64'h8000_0000_0000_0001;

    typedef struct packed {
        cmd_t              cmd;
        logic [KEY_W-1:0]  name_key;
        logic [INIT_W-1:0] init_value;
        logic [PID_W-1:0]  caller_pid;
    } sem_req_t;

    typedef struct packed {
        status_t           status;
        logic              must_block;
        logic              wake_valid;
        logic [PID_W-1:0]  wake_pid;
    } sem_rsp_t;

    typedef struct {
        sem_req_t req;
        bit       typed;
        sem_rsp_t rsp;
    } stim_row_t;

    logic clk;
    logic rst_n;

    nst_req_if req_ch ();
    nst_rsp_if rsp_ch ();

    named_semaphore_table u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    // predictor state
    bit                      sem_used   [NSEM];
    logic [KEY_W-1:0]        sem_key    [NSEM];
    logic signed [CNT_W-1:0] sem_count  [NSEM];
    logic [OPENS_W-1:0]      sem_opens  [NSEM];
    logic [PID_W-1:0]        waiter_pid [NSEM][QDEPTH];
    logic [HEAD_W-1:0]       waiter_head[NSEM];
    logic [LEN_W-1:0]        waiter_len [NSEM];

    sem_rsp_t         pending_rsp[$];
    stim_row_t        stim_rows[$];
    logic [KEY_W-1:0] key_pool[POOL_SIZE];
    int               err_cnt;
    int               sent;

    always #5 clk = ~clk;

    function automatic sem_rsp_t semaphore_outcome(sem_req_t w);
        sem_rsp_t         r;
        logic [KEY_W-1:0] k;
        int               hit;
        int               free_slot;
        int               cnt;
        int               pos;
        r = '0;
        r.status = ST_OK;
        k = w.name_key & KEY_MASK;
        hit = -1;
        free_slot = -1;
        for (int i = 0; i < NSEM; i++)
        begin
            if (sem_used[i] && sem_key[i] == k && hit < 0)
                hit = i;
            if (!sem_used[i] && free_slot < 0)
                free_slot = i;
        end
        if (w.cmd == CMD_OPEN)
        begin
            if (hit >= 0)
            begin
                if (sem_opens[hit] != OPENS_MAX)
                    sem_opens[hit] = sem_opens[hit] + 1'b1;
                r.status = ST_EXISTS;
            end
            else if (free_slot < 0)
                r.status = ST_NOSLOT;
            else
            begin
                sem_used[free_slot]    = 1'b1;
                sem_key[free_slot]     = k;
                sem_count[free_slot]   = $signed({1'b0, w.init_value});
                sem_opens[free_slot]   = 1;
                waiter_head[free_slot] = '0;
                waiter_len[free_slot]  = '0;
            end
        end
        else if (hit < 0)
            r.status = ST_NOTFOUND;
        else if (w.cmd == CMD_WAIT)
        begin
            cnt = sem_count[hit];
            if (cnt - 1 < 0)
            begin
                if (int'(waiter_len[hit]) >= QDEPTH)
                    r.status = ST_QFULL;
                else
                begin
                    pos = (int'(waiter_head[hit]) + int'(waiter_len[hit])) % QDEPTH;
                    waiter_pid[hit][pos] = w.caller_pid;
                    waiter_len[hit] = waiter_len[hit] + 1'b1;
                    sem_count[hit] = sem_count[hit] - CNT_ONE;
                    r.must_block = 1'b1;
                end
            end
            else
                sem_count[hit] = sem_count[hit] - CNT_ONE;
        end
        else if (w.cmd == CMD_POST)
        begin
            cnt = sem_count[hit];
            if (cnt < 65535)
                cnt = cnt + 1;
            sem_count[hit] = cnt[CNT_W-1:0];
            if (cnt <= 0 && waiter_len[hit] != 0)
            begin
                pos = int'(waiter_head[hit]) % QDEPTH;
                r.wake_pid = waiter_pid[hit][pos];
                r.wake_valid = 1'b1;
                waiter_head[hit] = HEAD_W'((pos + 1) % QDEPTH);
                waiter_len[hit] = waiter_len[hit] - 1'b1;
            end
        end
        else
        begin
            if (sem_opens[hit] != 0)
                sem_opens[hit] = sem_opens[hit] - 1'b1;
            if (sem_opens[hit] == 0)
            begin
                sem_used[hit]    = 1'b0;
                sem_key[hit]     = '0;
                sem_count[hit]   = CNT_ZERO;
                waiter_head[hit] = '0;
                waiter_len[hit]  = '0;
            end
        end
        return r;
    endfunction

    function automatic int sender_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 85)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 40);
    endfunction

    function automatic logic [INIT_W-1:0] pick_init();
        int r;
        r = $urandom_range(0, 99);
        if (r < 10)
            return 16'hffff;
        else if (r < 20)
            return INIT_W'($urandom_range(0, 65535));
        return INIT_W'($urandom_range(0, 3));
    endfunction

    task automatic add_row(input cmd_t c, input logic [KEY_W-1:0] k, input logic [INIT_W-1:0] iv,
                           input logic [PID_W-1:0] p, input bit typed, input status_t st,
                           input logic blk, input logic wv, input logic [PID_W-1:0] wp);
        stim_row_t row;
        row.req   = '{cmd: c, name_key: k, init_value: iv, caller_pid: p};
        row.typed = typed;
        row.rsp   = '{status: st, must_block: blk, wake_valid: wv, wake_pid: wp};
        stim_rows.push_back(row);
    endtask

    // called at a falling edge, returns at the falling edge after acceptance
    task automatic send_word(input sem_req_t w, input bit typed, input sem_rsp_t typed_rsp);
        sem_rsp_t pred;
        req_ch.valid      <= 1'b1;
        req_ch.cmd        <= w.cmd;
        req_ch.name_key   <= w.name_key;
        req_ch.init_value <= w.init_value;
        req_ch.caller_pid <= w.caller_pid;
        do
            @(posedge clk);
        while (!req_ch.ready);
        pred = semaphore_outcome(w);
        pending_rsp.push_back(typed ? typed_rsp : pred);
        sent++;
        @(negedge clk);
    endtask

    task automatic pace(input bit nogap);
        int g;
        g = nogap ? 0 : sender_gap();
        if (g > 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (g) @(negedge clk);
        end
    endtask

    task automatic drain_pending();
        req_ch.valid <= 1'b0;
        while (pending_rsp.size() != 0)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic issue(input cmd_t c, input logic [KEY_W-1:0] k, input logic [INIT_W-1:0] iv,
                         input logic [PID_W-1:0] p, input bit nogap);
        sem_req_t w;
        w = '{cmd: c, name_key: k, init_value: iv, caller_pid: p};
        send_word(w, 1'b0, '0);
        pace(nogap);
    endtask

    // response sink with random stalls
    initial
    begin
        int run;
        int gap;
        int r;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            r = $urandom_range(0, 99);
            run = (r < 75) ? $urandom_range(1, 8) : $urandom_range(20, 80);
            rsp_ch.ready <= 1'b1;
            repeat (run) @(negedge clk);
            r = $urandom_range(0, 99);
            if (r < 30)
                gap = 0;
            else if (r < 75)
                gap = $urandom_range(1, 3);
            else if (r < 97)
                gap = $urandom_range(4, 12);
            else
                gap = $urandom_range(20, 40);
            if (gap > 0)
            begin
                rsp_ch.ready <= 1'b0;
                repeat (gap - 1) @(negedge clk);
            end
        end
    end

    always @(posedge clk)
    begin
        sem_rsp_t want;
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            if (pending_rsp.size() == 0)
            begin
                $error("response word with nothing pending");
                err_cnt++;
            end
            else
            begin
                want = pending_rsp.pop_front();
                if (rsp_ch.status !== want.status)
                begin
                    $error("status: expected %0d, got %0d", want.status, rsp_ch.status);
                    err_cnt++;
                end
                if (rsp_ch.must_block !== want.must_block)
                begin
                    $error("must_block: expected %0d, got %0d", want.must_block,
                           rsp_ch.must_block);
                    err_cnt++;
                end
                if (rsp_ch.wake_valid !== want.wake_valid)
                begin
                    $error("wake_valid: expected %0d, got %0d", want.wake_valid,
                           rsp_ch.wake_valid);
                    err_cnt++;
                end
                if (rsp_ch.wake_pid !== want.wake_pid)
                begin
                    $error("wake_pid: expected %0d, got %0d", want.wake_pid, rsp_ch.wake_pid);
                    err_cnt++;
                end
            end
        end
    end

    initial
    begin
        #(10_000_000);
        $display("TB_ERROR");
        $finish;
    end

    initial
    begin
        int               kind;
        int               n;
        int               m;
        int               base;
        int               r;
        bit               nogap;
        bit               sat_done;
        logic [KEY_W-1:0] k;
        cmd_t             c;

        clk = 1'b0;
        rst_n = 1'b0;
        req_ch.valid = 1'b0;
        req_ch.cmd = CMD_OPEN;
        req_ch.name_key = '0;
        req_ch.init_value = '0;
        req_ch.caller_pid = '0;
        rsp_ch.ready = 1'b0;
        err_cnt = 0;
        sent = 0;
        sat_done = 1'b0;
        for (int i = 0; i < NSEM; i++)
        begin
            sem_used[i]    = 1'b0;
            sem_key[i]     = '0;
            sem_count[i]   = CNT_ZERO;
            sem_opens[i]   = '0;
            waiter_head[i] = '0;
            waiter_len[i]  = '0;
        end
        for (int i = 0; i < POOL_SIZE; i++)
            key_pool[i] = {$urandom(), $urandom()};

        // unknown key, extremes, wake order, close with waiters left
        add_row(CMD_WAIT,  KEY_ODD,  16'd0,     8'd7,   1, ST_NOTFOUND, 0, 0, 8'd0);
        add_row(CMD_POST,  KEY_ODD,  16'd0,     8'd0,   1, ST_NOTFOUND, 0, 0, 8'd0);
        add_row(CMD_CLOSE, KEY_ODD,  16'd0,     8'd0,   1, ST_NOTFOUND, 0, 0, 8'd0);
        add_row(CMD_OPEN,  KEY_ZERO, 16'd0,     8'd0,   1, ST_OK,       0, 0, 8'd0);
        add_row(CMD_OPEN,  KEY_ONES, 16'hffff,  8'd0,   1, ST_OK,       0, 0, 8'd0);
        add_row(CMD_POST,  KEY_ONES, 16'd0,     8'd0,   1, ST_OK,       0, 0, 8'd0);
        add_row(CMD_WAIT,  KEY_ONES, 16'd0,     8'd3,   1, ST_OK,       0, 0, 8'd0);
        add_row(CMD_OPEN,  KEY_ZERO, 16'd5,     8'd0,   1, ST_EXISTS,   0, 0, 8'd0);
        add_row(CMD_WAIT,  KEY_ZERO, 16'd0,     8'd255, 1, ST_OK,       1, 0, 8'd0);
        add_row(CMD_WAIT,  KEY_ZERO, 16'd0,     8'd0,   1, ST_OK,       1, 0, 8'd0);
        add_row(CMD_POST,  KEY_ZERO, 16'd0,     8'd0,   1, ST_OK,       0, 1, 8'd255);
        add_row(CMD_POST,  KEY_ZERO, 16'd0,     8'd0,   1, ST_OK,       0, 1, 8'd0);
        add_row(CMD_POST,  KEY_ZERO, 16'd0,     8'd0,   1, ST_OK,       0, 0, 8'd0);
        add_row(CMD_CLOSE, KEY_ZERO, 16'd0,     8'd0,   1, ST_OK,       0, 0, 8'd0);
        add_row(CMD_CLOSE, KEY_ZERO, 16'd0,     8'd0,   1, ST_OK,       0, 0, 8'd0);
        add_row(CMD_WAIT,  KEY_ZERO, 16'd0,     8'd1,   1, ST_NOTFOUND, 0, 0, 8'd0);
        add_row(CMD_OPEN,  KEY_ZERO, 16'd1,     8'd0,   1, ST_OK,       0, 0, 8'd0);
        add_row(CMD_WAIT,  KEY_ZERO, 16'd0,     8'h5a,  1, ST_OK,       0, 0, 8'd0);
        add_row(CMD_WAIT,  KEY_ZERO, 16'd0,     8'ha5,  1, ST_OK,       1, 0, 8'd0);
        add_row(CMD_CLOSE, KEY_ZERO, 16'd0,     8'd0,   1, ST_OK,       0, 0, 8'd0);
        add_row(CMD_OPEN,  KEY_ZERO, 16'd0,     8'd0,   1, ST_OK,       0, 0, 8'd0);
        add_row(CMD_POST,  KEY_ZERO, 16'd0,     8'd0,   1, ST_OK,       0, 0, 8'd0);
        add_row(CMD_CLOSE, KEY_ONES, 16'd0,     8'd0,   0, ST_OK,       0, 0, 8'd0);
        add_row(CMD_CLOSE, KEY_ZERO, 16'd0,     8'd0,   0, ST_OK,       0, 0, 8'd0);

        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (stim_rows[i])
        begin
            send_word(stim_rows[i].req, stim_rows[i].typed, stim_rows[i].rsp);
            pace(1'b0);
        end
        drain_pending();

        while (sent < ITEM_TARGET)
        begin
            kind = $urandom_range(0, 99);
            nogap = ($urandom_range(0, 4) == 0);
            if ($urandom_range(0, 9) == 0)
                drain_pending();
            if (!sat_done && sent > 500)
            begin
                // open count saturation and the long way back to free
                sat_done = 1'b1;
                k = key_pool[$urandom_range(0, POOL_SIZE - 1)];
                repeat (260)
                    issue(CMD_OPEN, k, pick_init(), PID_W'($urandom_range(0, 255)), 1'b1);
                repeat (258)
                    issue(CMD_CLOSE, k, '0, PID_W'($urandom_range(0, 255)), 1'b1);
            end
            else if (kind < 55)
            begin
                n = $urandom_range(20, 60);
                repeat (n)
                begin
                    r = $urandom_range(0, 99);
                    if (r < 25)
                        c = CMD_OPEN;
                    else if (r < 55)
                        c = CMD_WAIT;
                    else if (r < 82)
                        c = CMD_POST;
                    else
                        c = CMD_CLOSE;
                    issue(c, key_pool[$urandom_range(0, POOL_SIZE - 1)], pick_init(),
                          PID_W'($urandom_range(0, 255)), nogap);
                end
            end
            else if (kind < 75)
            begin
                // fill a wait queue, overflowing it on some runs, then release
                k = key_pool[$urandom_range(0, POOL_SIZE - 1)];
                issue(CMD_OPEN, k, INIT_W'($urandom_range(0, 2)),
                      PID_W'($urandom_range(0, 255)), nogap);
                n = $urandom_range(12, 20);
                repeat (n)
                    issue(CMD_WAIT, k, INIT_W'($urandom_range(0, 65535)),
                          PID_W'($urandom_range(0, 255)), nogap);
                m = $urandom_range(8, 22);
                repeat (m)
                    issue(CMD_POST, k, INIT_W'($urandom_range(0, 65535)),
                          PID_W'($urandom_range(0, 255)), nogap);
                if ($urandom_range(0, 1) == 0)
                    issue(CMD_CLOSE, k, '0, '0, nogap);
            end
            else if (kind < 88)
            begin
                // run the table full, then free part of it
                base = $urandom_range(0, POOL_SIZE - 1);
                for (int i = 0; i < 18; i++)
                    issue(CMD_OPEN, key_pool[(base + i) % POOL_SIZE], pick_init(),
                          PID_W'($urandom_range(0, 255)), nogap);
                for (int i = 0; i < 18; i++)
                begin
                    if ($urandom_range(0, 9) < 7)
                        issue(CMD_CLOSE, key_pool[(base + i) % POOL_SIZE], '0, '0, nogap);
                    if ($urandom_range(0, 9) < 3)
                        issue(CMD_CLOSE, key_pool[(base + i) % POOL_SIZE], '0, '0, nogap);
                end
            end
            else
            begin
                n = $urandom_range(5, 15);
                repeat (n)
                begin
                    k = {$urandom(), $urandom()};
                    if ($urandom_range(0, 4) == 0)
                    begin
                        issue(CMD_OPEN, k, INIT_W'($urandom_range(0, 65535)),
                              PID_W'($urandom_range(0, 255)), nogap);
                        issue(CMD_CLOSE, k, INIT_W'($urandom_range(0, 65535)),
                              PID_W'($urandom_range(0, 255)), nogap);
                    end
                    else
                        issue(cmd_t'($urandom_range(1, 3)), k, INIT_W'($urandom_range(0, 65535)),
                              PID_W'($urandom_range(0, 255)), nogap);
                end
            end
        end

        req_ch.valid <= 1'b0;
        while (pending_rsp.size() != 0)
            @(posedge clk);
        repeat (2 * LATENCY) @(posedge clk);
        if (err_cnt == 0 && pending_rsp.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
